[rtl/rrp_pkg.sv]
// Shared types, constants and register indexes of the receive ring record parser.
// No dependencies; every other file in rtl imports this package.
package rrp_pkg;

  localparam int unsigned RRP_RING_SIZE     = 32768;
  localparam int unsigned RRP_POS_W         = 17;
  localparam int unsigned RRP_LEN_W         = 16;
  localparam int unsigned RRP_PTR_W         = 15;
  localparam int unsigned RRP_CNT_W         = 32;
  localparam int unsigned RRP_CFG_IDX_W     = 2;
  localparam int unsigned RRP_CFG_DATA_W    = 16;

  localparam logic [15:0] RRP_HDR_BYTES     = 16'd4;
  localparam logic [15:0] RRP_CRC_BYTES     = 16'd4;
  localparam logic [16:0] RRP_PAD_ROUND     = 17'd3;
  localparam logic [16:0] RRP_PTR_BACKOFF   = 17'd16;
  localparam logic [15:0] RRP_MAX_REC_RST   = 16'd8192;
  localparam logic [15:0] RRP_MAX_PAY_RST   = 16'd1600;

  localparam logic [RRP_CFG_IDX_W-1:0] REG_RX_ENABLE      = 2'd0;
  localparam logic [RRP_CFG_IDX_W-1:0] REG_MAX_RECORD_LEN = 2'd1;
  localparam logic [RRP_CFG_IDX_W-1:0] REG_MAX_PAYLOAD_LEN = 2'd2;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_RECORD  = 2'd1,
    KIND_LEN_ERR = 2'd2
  } result_kind_e;

  typedef struct packed {
    logic                 rx_enable;
    logic [RRP_LEN_W-1:0] max_record_len;
    logic [RRP_LEN_W-1:0] max_payload_len;
  } cfg_t;

  typedef struct packed {
    result_kind_e         kind;
    logic [7:0]           payload_data;
    logic                 last_byte;
    logic [RRP_PTR_W-1:0] read_pointer;
    logic                 delivered;
    logic                 receive_error;
    logic [RRP_CNT_W-1:0] dropped_total;
    logic [RRP_CNT_W-1:0] delivered_total;
  } result_t;

endpackage

[rtl/rrp_cfg_regs.sv]
// Configuration registers of the receive ring record parser.
// Depends on rrp_pkg for the register indexes and the cfg_t struct.
module rrp_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rrp_pkg::RRP_CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rrp_pkg::RRP_CFG_DATA_W-1:0]   cfg_wdata_i,
  output rrp_pkg::cfg_t                        cfg_o
);
  import rrp_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rx_enable       <= 1'b1;
      cfg_q.max_record_len  <= RRP_MAX_REC_RST;
      cfg_q.max_payload_len <= RRP_MAX_PAY_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_RX_ENABLE:       cfg_q.rx_enable       <= cfg_wdata_i[0];
        REG_MAX_RECORD_LEN:  cfg_q.max_record_len  <= cfg_wdata_i;
        REG_MAX_PAYLOAD_LEN: cfg_q.max_payload_len <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/rrp_step.sv]
// Record state and per-byte parsing step of the receive ring record parser.
// Depends on rrp_pkg; the result it forms is captured by rrp_out_reg.
module rrp_step #(
  parameter int unsigned RING_SIZE = rrp_pkg::RRP_RING_SIZE
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rrp_pkg::cfg_t     cfg_i,
  input  logic              fire_i,
  input  logic [7:0]        byte_i,
  output logic              res_valid_o,
  output rrp_pkg::result_t  res_o
);
  import rrp_pkg::*;

  localparam int unsigned OFS_W = $clog2(RING_SIZE);

  logic [OFS_W-1:0]     offset_q, offset_d, offset_inc;
  logic [RRP_POS_W-1:0] pos_q, pos_d, pos_inc, len_ext, rec_size;
  logic [RRP_LEN_W-1:0] len_q, len_d, len_new;
  logic                 status_q, status_d;
  logic                 oversize_q, oversize_d;
  logic                 halted_q, halted_d;
  logic [RRP_CNT_W-1:0] drops_q, drops_d;
  logic [RRP_CNT_W-1:0] packets_q, packets_d;
  logic                 bad_len;
  logic                 use_next_ofs;
  logic [16:0]          ptr_src, ptr_wide;

  assign offset_inc = (offset_q == OFS_W'(RING_SIZE - 1)) ? '0 : offset_q + 1'b1;
  assign pos_inc    = pos_q + 1'b1;
  assign len_ext    = {1'b0, len_q};
  assign rec_size   = (len_ext + 17'(RRP_CRC_BYTES) + RRP_PAD_ROUND) & ~RRP_PAD_ROUND;
  assign len_new    = {byte_i, len_q[7:0]};
  assign bad_len    = (len_new < RRP_HDR_BYTES) || (len_new > cfg_i.max_record_len);

  assign ptr_src  = use_next_ofs ? 17'(offset_inc) : 17'(offset_q);
  assign ptr_wide = (ptr_src >= RRP_PTR_BACKOFF) ? ptr_src - RRP_PTR_BACKOFF
                                                 : ptr_src + 17'(RING_SIZE) - RRP_PTR_BACKOFF;

  always_comb begin
    offset_d     = offset_q;
    pos_d        = pos_q;
    len_d        = len_q;
    status_d     = status_q;
    oversize_d   = oversize_q;
    halted_d     = halted_q;
    drops_d      = drops_q;
    packets_d    = packets_q;
    use_next_ofs = 1'b0;
    res_valid_o  = 1'b0;
    res_o        = '0;
    res_o.kind   = KIND_PAYLOAD;

    if (fire_i && cfg_i.rx_enable && !halted_q) begin
      if (pos_q < 17'(RRP_HDR_BYTES)) begin
        offset_d = offset_inc;
        pos_d    = pos_inc;
        case (pos_q[1:0])
          2'd0: status_d = byte_i[0];
          2'd2: len_d = {8'h00, byte_i};
          2'd3: begin
            len_d = len_new;
            if (bad_len) begin
              offset_d              = offset_q;
              pos_d                 = pos_q;
              halted_d              = 1'b1;
              drops_d               = drops_q + 1'b1;
              res_valid_o           = 1'b1;
              res_o.kind            = KIND_LEN_ERR;
              res_o.read_pointer    = ptr_wide[RRP_PTR_W-1:0];
              res_o.dropped_total   = drops_q + 1'b1;
              res_o.delivered_total = packets_q;
            end else begin
              oversize_d = (len_new - RRP_HDR_BYTES) > cfg_i.max_payload_len;
            end
          end
          default: ;
        endcase
      end else begin
        offset_d = offset_inc;
        if (pos_q < len_ext) begin
          pos_d = pos_inc;
          if (!oversize_q) begin
            res_valid_o        = 1'b1;
            res_o.payload_data = byte_i;
            res_o.last_byte    = (pos_inc == len_ext);
          end
        end else if (pos_inc < rec_size) begin
          pos_d = pos_inc;
        end else begin
          use_next_ofs = 1'b1;
          drops_d      = drops_q + RRP_CNT_W'(oversize_q) + RRP_CNT_W'(!status_q);
          packets_d    = packets_q + RRP_CNT_W'(!oversize_q);
          pos_d        = '0;
          len_d        = '0;
          oversize_d   = 1'b0;
          status_d     = 1'b0;
          res_valid_o           = 1'b1;
          res_o.kind            = KIND_RECORD;
          res_o.read_pointer    = ptr_wide[RRP_PTR_W-1:0];
          res_o.delivered       = !oversize_q;
          res_o.receive_error   = !status_q;
          res_o.dropped_total   = drops_d;
          res_o.delivered_total = packets_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= '0;
      pos_q      <= '0;
      len_q      <= '0;
      status_q   <= 1'b0;
      oversize_q <= 1'b0;
      halted_q   <= 1'b0;
      drops_q    <= '0;
      packets_q  <= '0;
    end else begin
      offset_q   <= offset_d;
      pos_q      <= pos_d;
      len_q      <= len_d;
      status_q   <= status_d;
      oversize_q <= oversize_d;
      halted_q   <= halted_d;
      drops_q    <= drops_d;
      packets_q  <= packets_d;
    end
  end

endmodule

[rtl/rrp_out_reg.sv]
// Result register of the receive ring record parser, holding one beat for the sink.
// Depends on rrp_pkg for the result_t struct.
module rrp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_valid_i,
  input  rrp_pkg::result_t  load_data_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rrp_pkg::result_t  out_data_o
);
  import rrp_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (can_load_o) begin
      valid_d = load_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && load_valid_i) begin
      data_q <= load_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[rtl/rx_ring_record_parser.sv]
// Top level of the receive ring record parser: input register, parsing step, result register.
// Depends on rrp_pkg, rrp_cfg_regs, rrp_step and rrp_out_reg.
//
//   Port group   Direction  Handshake                  Beat
//   in           sink       in_valid_i / in_ready_o    one ring byte
//   out          source     out_valid_o / out_ready_i  one payload byte, record report or length error report
//   cfg          sink       cfg_we_i                   one register write
//
// The parsing step handles each ring byte in turn; a byte enters each cycle unless the sink stalls.
// A byte sits in the input register, and the step runs when the result register can load.
// An accepted byte passes through the input register, and its result beat, if any, is held in the result register.
// Reset clears all record state and counters, and restores the register defaults.
// A stalled sink holds the result register and, through it, the input register.
module rx_ring_record_parser #(
  parameter int unsigned RING_SIZE = rrp_pkg::RRP_RING_SIZE
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          ring_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          result_kind_o,
  output logic [7:0]                          payload_data_o,
  output logic                                last_byte_o,
  output logic [rrp_pkg::RRP_PTR_W-1:0]       read_pointer_o,
  output logic                                delivered_o,
  output logic                                receive_error_o,
  output logic [rrp_pkg::RRP_CNT_W-1:0]       dropped_total_o,
  output logic [rrp_pkg::RRP_CNT_W-1:0]       delivered_total_o,
  input  logic                                cfg_we_i,
  input  logic [rrp_pkg::RRP_CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rrp_pkg::RRP_CFG_DATA_W-1:0]  cfg_wdata_i
);
  import rrp_pkg::*;

  cfg_t       cfg;
  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       can_load;
  logic       step_go;
  logic       res_valid;
  result_t    res;
  result_t    out_data;

  assign step_go    = in_valid_q && can_load;
  assign in_ready_o = !in_valid_q || step_go;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= ring_byte_i;
    end
  end

  rrp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rrp_step #(
    .RING_SIZE (RING_SIZE)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .fire_i      (step_go),
    .byte_i      (byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rrp_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (step_go && res_valid),
    .load_data_i  (res),
    .can_load_o   (can_load),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data)
  );

  assign result_kind_o     = out_data.kind;
  assign payload_data_o    = out_data.payload_data;
  assign last_byte_o       = out_data.last_byte;
  assign read_pointer_o    = out_data.read_pointer;
  assign delivered_o       = out_data.delivered;
  assign receive_error_o   = out_data.receive_error;
  assign dropped_total_o   = out_data.dropped_total;
  assign delivered_total_o = out_data.delivered_total;

endmodule

[bench/rx_ring_record_parser_test.sv]
// Self-checking bench for rx_ring_record_parser: drives ring bytes, keeps its own parser state
// and compares every result beat field by field. Depends on rrp_pkg and the RTL top level only.
module rx_ring_record_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rrp_pkg::*;

  localparam int unsigned RING           = RRP_RING_SIZE;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SINK_HOLD      = 300;
  localparam int unsigned PHASE_BEATS    = 170;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [7:0]                ring_byte_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [1:0]                result_kind_o;
  logic [7:0]                payload_data_o;
  logic                      last_byte_o;
  logic [RRP_PTR_W-1:0]      read_pointer_o;
  logic                      delivered_o;
  logic                      receive_error_o;
  logic [RRP_CNT_W-1:0]      dropped_total_o;
  logic [RRP_CNT_W-1:0]      delivered_total_o;
  logic                      cfg_we_i;
  logic [RRP_CFG_IDX_W-1:0]  cfg_index_i;
  logic [RRP_CFG_DATA_W-1:0] cfg_wdata_i;

  rx_ring_record_parser i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .ring_byte_i      (ring_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_o    (result_kind_o),
    .payload_data_o   (payload_data_o),
    .last_byte_o      (last_byte_o),
    .read_pointer_o   (read_pointer_o),
    .delivered_o      (delivered_o),
    .receive_error_o  (receive_error_o),
    .dropped_total_o  (dropped_total_o),
    .delivered_total_o(delivered_total_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  logic        rx_en     = 1'b1;
  int unsigned rec_limit = RRP_MAX_REC_RST;
  int unsigned pay_limit = RRP_MAX_PAY_RST;
  int unsigned ring_ofs  = 0;
  int unsigned rec_pos   = 0;
  int unsigned rec_len   = 0;
  logic        stat_ok   = 1'b0;
  logic        skip_rec  = 1'b0;
  logic        halted    = 1'b0;
  int unsigned drop_cnt  = 0;
  int unsigned pkt_cnt   = 0;

  result_t     pending_reports[$];

  logic        idling      = 1'b1;
  int unsigned sink_hold   = 0;
  int unsigned ring_beats  = 0;
  int unsigned mismatches  = 0;
  int unsigned records_seen = 0;
  int unsigned payload_seen = 0;
  int unsigned len_err_seen = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [RRP_PTR_W-1:0] read_ptr();
    return RRP_PTR_W'((ring_ofs + RING - 16) % RING);
  endfunction

  task automatic parse_ring_byte(input logic [7:0] b);
    result_t     r;
    int unsigned pay_len;
    int unsigned span;
    r = '0;
    if (!rx_en || halted) return;
    if (rec_pos < 4) begin
      if (rec_pos == 0) begin
        stat_ok = b[0];
      end else if (rec_pos == 2) begin
        rec_len = 32'(b);
      end else if (rec_pos == 3) begin
        rec_len = rec_len | (int'(b) << 8);
        if (rec_len < 4 || rec_len > rec_limit) begin
          drop_cnt++;
          halted = 1'b1;
          r.kind            = KIND_LEN_ERR;
          r.read_pointer    = read_ptr();
          r.dropped_total   = drop_cnt;
          r.delivered_total = pkt_cnt;
          pending_reports.push_back(r);
          return;
        end
        skip_rec = (rec_len - 4 > pay_limit);
      end
      ring_ofs = (ring_ofs + 1) % RING;
      rec_pos++;
      return;
    end
    pay_len  = rec_len - 4;
    span     = (rec_len + 7) & ~32'd3;
    ring_ofs = (ring_ofs + 1) % RING;
    if (rec_pos < 4 + pay_len) begin
      r.last_byte = (rec_pos == 3 + pay_len);
      rec_pos++;
      if (!skip_rec) begin
        r.kind         = KIND_PAYLOAD;
        r.payload_data = b;
        pending_reports.push_back(r);
      end
      return;
    end
    if (rec_pos + 1 < span) begin
      rec_pos++;
      return;
    end
    if (skip_rec) drop_cnt++;
    else pkt_cnt++;
    if (!stat_ok) drop_cnt++;
    r.kind            = KIND_RECORD;
    r.read_pointer    = read_ptr();
    r.delivered       = !skip_rec;
    r.receive_error   = !stat_ok;
    r.dropped_total   = drop_cnt;
    r.delivered_total = pkt_cnt;
    pending_reports.push_back(r);
    rec_pos  = 0;
    rec_len  = 0;
    skip_rec = 1'b0;
    stat_ok  = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin : check_beat
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected beat kind", 32'(result_kind_o), '0);
      end else begin
        want = pending_reports.pop_front();
        case (want.kind)
          KIND_PAYLOAD: payload_seen++;
          KIND_RECORD:  records_seen++;
          default:      len_err_seen++;
        endcase
        if (result_kind_o !== want.kind)
          report_mismatch("result_kind", 32'(result_kind_o), 32'(want.kind));
        if (payload_data_o !== want.payload_data)
          report_mismatch("payload_data", 32'(payload_data_o), 32'(want.payload_data));
        if (last_byte_o !== want.last_byte)
          report_mismatch("last_byte", 32'(last_byte_o), 32'(want.last_byte));
        if (read_pointer_o !== want.read_pointer)
          report_mismatch("read_pointer", 32'(read_pointer_o), 32'(want.read_pointer));
        if (delivered_o !== want.delivered)
          report_mismatch("delivered", 32'(delivered_o), 32'(want.delivered));
        if (receive_error_o !== want.receive_error)
          report_mismatch("receive_error", 32'(receive_error_o), 32'(want.receive_error));
        if (dropped_total_o !== want.dropped_total)
          report_mismatch("dropped_total", dropped_total_o, want.dropped_total);
        if (delivered_total_o !== want.delivered_total)
          report_mismatch("delivered_total", delivered_total_o, want.delivered_total);
      end
    end
  end

  initial begin : sink
    int unsigned stall;
    stall = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (sink_hold != 0) begin
        sink_hold--;
        out_ready_i <= 1'b0;
      end else if (stall != 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 8);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("** rx_ring_record_parser: FAILED **");
    $finish;
  end

  task automatic put_ring_byte(input logic [7:0] b);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    ring_byte_i <= b;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    parse_ring_byte(b);
    ring_beats++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [RRP_CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      REG_RX_ENABLE:       rx_en = value[0];
      REG_MAX_RECORD_LEN:  rec_limit = 32'(value);
      REG_MAX_PAYLOAD_LEN: pay_limit = 32'(value);
      default: ;
    endcase
  endtask

  task automatic send_header(input int unsigned len, input logic ok);
    logic [7:0] status_lo;
    status_lo    = 8'($urandom);
    status_lo[0] = ok;
    put_ring_byte(status_lo);
    put_ring_byte(8'($urandom));
    put_ring_byte(len[7:0]);
    put_ring_byte(len[15:8]);
  endtask

  task automatic send_record(input int unsigned len, input logic ok, input int fill = -1);
    int unsigned span;
    span = (len + 7) & ~32'd3;
    send_header(len, ok);
    for (int unsigned i = 4; i < span; i++)
      put_ring_byte((fill < 0 || i >= len) ? 8'($urandom) : 8'(fill));
  endtask

  function automatic int unsigned pick_length(input int unsigned limit, input int unsigned pay);
    int unsigned len;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10 && pay + 5 <= limit) len = pay + 4 + $urandom_range(0, 1);
    else if (roll < 70) len = $urandom_range(4, 24);
    else if (roll < 95) len = $urandom_range(4, 100);
    else len = $urandom_range(4, 300);
    if (len > limit) len = $urandom_range(4, limit);
    return len;
  endfunction

  task automatic test_directed_records();
    send_record(4, 1'b1);
    send_record(5, 1'b1, 0);
    send_record(9, 1'b1, 255);
    send_record(7, 1'b0);
    send_record(4, 1'b0);
    wait_idle();
    write_reg(REG_MAX_RECORD_LEN, 16'd16);
    write_reg(REG_MAX_PAYLOAD_LEN, 16'd8);
    send_record(12, 1'b1);
    send_record(13, 1'b1);
    send_record(13, 1'b0);
    send_record(16, 1'b1);
    send_record(16, 1'b0, 255);
    wait_idle();
  endtask

  task automatic test_receive_disabled();
    write_reg(REG_RX_ENABLE, 16'd0);
    repeat (20) put_ring_byte(8'($urandom));
    wait_idle();
    write_reg(REG_RX_ENABLE, 16'hFFFF);
    send_record(10, 1'b1);
    wait_idle();
  endtask

  task automatic test_sink_backpressure();
    write_reg(REG_MAX_RECORD_LEN, 16'd8192);
    write_reg(REG_MAX_PAYLOAD_LEN, 16'd1600);
    sink_hold = SINK_HOLD;
    send_record(260, 1'b1);
    wait_idle();
  endtask

  task automatic test_longest_record();
    write_reg(REG_MAX_RECORD_LEN, 16'hFFFF);
    write_reg(REG_MAX_PAYLOAD_LEN, 16'd300);
    send_record(304, 1'($urandom));
    send_record(20, 1'b1);
    wait_idle();
  endtask

  task automatic run_random_phase(input int unsigned rec_max, input int unsigned pay_max);
    int unsigned start;
    write_reg(REG_MAX_RECORD_LEN, 16'(rec_max));
    write_reg(REG_MAX_PAYLOAD_LEN, 16'(pay_max));
    start = ring_beats;
    while (ring_beats - start < PHASE_BEATS)
      send_record(pick_length(rec_limit, pay_limit), $urandom_range(0, 3) != 0);
    wait_idle();
  endtask

  task automatic test_random_records();
    int unsigned rec_max;
    run_random_phase(65535, 65535);
    run_random_phase(65535, 0);
    run_random_phase(4, 0);
    rec_max = $urandom_range(20, 400);
    run_random_phase(rec_max, $urandom_range(0, rec_max));
    idling = 1'b0;
    run_random_phase($urandom_range(8, 1000), $urandom_range(0, 64));
  endtask

  task automatic test_length_error();
    int unsigned len;
    if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_MAX_RECORD_LEN, 16'($urandom_range(4, 65534)));
      len = $urandom_range(rec_limit + 1, 65535);
    end else begin
      len = $urandom_range(0, 3);
    end
    send_record(8, 1'b1);
    send_header(len, 1'($urandom));
    repeat (12) put_ring_byte(8'($urandom));
    wait_idle();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    ring_byte_i = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_records();
    test_receive_disabled();
    test_sink_backpressure();
    test_longest_record();
    test_random_records();
    test_length_error();
    repeat (8) @(negedge clk_i);

    $display("Sent %0d ring bytes; checked %0d payload beats, %0d record reports, %0d halts.",
             ring_beats, payload_seen, records_seen, len_err_seen);
    $display("Limits went from 4 to 65535 bytes, with a long sink stall.");
    if (mismatches == 0) begin
      $display("** rx_ring_record_parser: PASSED **");
    end else begin
      $display("** rx_ring_record_parser: FAILED **");
    end
    $finish;
  end

endmodule
